// File: hw/rtl/tuhfc_pkg.sv
// constants and letter tables shared by the frame classifier
`timescale 1ns / 1ps
`default_nettype none

package tuhfc_pkg;

  localparam int MAX_FRAME_BYTES_DEFAULT = 65535;
  localparam logic [15:0] WATCH_PORT_RESET = 16'd80;

  // byte positions within the frame
  localparam logic [15:0] POS_IHL       = 16'd14;
  localparam logic [15:0] POS_PROTO     = 16'd23;
  localparam logic [15:0] POS_SRC_FIRST = 16'd26;
  localparam logic [15:0] POS_SRC_LAST  = 16'd29;
  localparam logic [15:0] POS_DST_FIRST = 16'd30;
  localparam logic [15:0] POS_DST_LAST  = 16'd33;
  localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;

  localparam logic [6:0] ETH_HDR_BYTES = 7'd14;
  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam logic [4:0] TCP_OFF_BYTE  = 5'd12;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // register map, decoded on paddr[2]
  localparam logic REG_WATCH_PORT = 1'b0;

  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_P = 8'h50;
  localparam logic [7:0] CHAR_O = 8'h4F;
  localparam logic [7:0] CHAR_S = 8'h53;

  function automatic logic [7:0] get_letter(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_G;
      2'd1:    c = CHAR_E;
      2'd2:    c = CHAR_T;
      default: c = CHAR_G;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] post_letter(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_P;
      2'd1:    c = CHAR_O;
      2'd2:    c = CHAR_S;
      2'd3:    c = CHAR_T;
      default: c = CHAR_P;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tcp_udp_http_frame_classifier_core.sv
// Ethernet frame classifier: header fields, watched TCP port and HTTP request search
//
// Usage: frame bytes arrive one word per cycle on data/last with in_valid and
// in_stall; a word is taken at a clock edge where in_valid is high and
// in_stall low. The word carrying last produces one result word on
// out_valid/out_stall: short-frame flag, TCP/UDP flags, watched-port hit,
// HTTP request flag, IPv4 source and destination and the frame length.
// Throughput is one byte per cycle when not stalled, set by the single registered
// pass over the per-frame header registers and the two small string matchers.
// Latency: the result is valid on the cycle after the last byte is taken.
// The result register holds its word while out_stall is high; in that case
// in_stall rises so no further byte is taken until the word is gone.
// watch_port is written over the APB port at byte address 0 (reset 80).
// Synchronous reset clears the frame state and the result valid flag and
// restores watch_port; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module tcp_udp_http_frame_classifier_core
  import tuhfc_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data,
  input  wire logic        last,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             too_short,
  output logic             is_tcp,
  output logic             is_udp,
  output logic             port_hit,
  output logic             http_request,
  output logic [31:0]      src_addr,
  output logic [31:0]      dst_addr,
  output logic [15:0]      frame_len,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [15:0] MAX_CNT = 16'(MAX_FRAME_BYTES);

  logic [15:0] watch_port;

  logic [15:0] byte_count, byte_count_next;
  logic [3:0]  ip_header_words, ip_header_words_next;
  logic [7:0]  protocol_code, protocol_code_next;
  logic [3:0]  tcp_header_words, tcp_header_words_next;
  logic [15:0] source_port, source_port_next;
  logic [15:0] dest_port, dest_port_next;
  logic [31:0] source_ip, source_ip_next;
  logic [31:0] dest_ip, dest_ip_next;
  logic [1:0]  get_progress, get_progress_next;
  logic [2:0]  post_progress, post_progress_next;
  logic        request_seen, request_seen_next;

  logic        in_accept;
  logic        take;
  logic [3:0]  ihl_eff, off_eff;
  logic [6:0]  tcp_start;
  logic [7:0]  pay_start;
  logic [15:0] t16, p16;
  logic        match_on;

  logic        short_f, tcp_f, udp_f, ports_ok;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_WATCH_PORT) ? {16'b0, watch_port} : 32'b0;
  assign in_stall = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_port <= WATCH_PORT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WATCH_PORT) begin
      watch_port <= pwdata[15:0];
    end
  end

  // header offsets; an ihl or data offset below five counts as five
  assign ihl_eff   = (ip_header_words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : ip_header_words;
  assign off_eff   = (tcp_header_words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : tcp_header_words;
  assign tcp_start = ETH_HDR_BYTES + {1'b0, ihl_eff, 2'b00};
  assign pay_start = {1'b0, tcp_start} + {2'b00, off_eff, 2'b00};
  assign t16       = {9'b0, tcp_start};
  assign p16       = {8'b0, pay_start};

  assign take = byte_count < MAX_CNT;

  always_comb begin
    byte_count_next       = byte_count;
    ip_header_words_next  = ip_header_words;
    protocol_code_next    = protocol_code;
    tcp_header_words_next = tcp_header_words;
    source_port_next      = source_port;
    dest_port_next        = dest_port;
    source_ip_next        = source_ip;
    dest_ip_next          = dest_ip;
    get_progress_next     = get_progress;
    post_progress_next    = post_progress;
    request_seen_next     = request_seen;
    match_on              = 1'b0;

    if (take) begin
      byte_count_next = byte_count + 16'd1;
      if (byte_count == POS_IHL) begin
        ip_header_words_next = data[3:0];
      end
      if (byte_count == POS_PROTO) begin
        protocol_code_next = data;
      end
      if (byte_count >= POS_SRC_FIRST && byte_count <= POS_SRC_LAST) begin
        source_ip_next = {source_ip[23:0], data};
      end
      if (byte_count >= POS_DST_FIRST && byte_count <= POS_DST_LAST) begin
        dest_ip_next = {dest_ip[23:0], data};
      end
      // tcp header always starts past the ip addresses
      if (byte_count == t16 || byte_count == t16 + 16'd1) begin
        source_port_next = {source_port[7:0], data};
      end
      if (byte_count == t16 + 16'd2 || byte_count == t16 + 16'd3) begin
        dest_port_next = {dest_port[7:0], data};
      end
      if (byte_count == t16 + {11'b0, TCP_OFF_BYTE}) begin
        tcp_header_words_next = data[7:4];
      end
      match_on = (protocol_code == PROTO_TCP) && (byte_count >= p16);
    end

    if (match_on) begin
      if (data == get_letter(get_progress)) begin
        if (get_progress == 2'd2) begin
          request_seen_next = 1'b1;
          get_progress_next = 2'd0;
        end else begin
          get_progress_next = get_progress + 2'd1;
        end
      end else begin
        get_progress_next = (data == CHAR_G) ? 2'd1 : 2'd0;
      end

      if (data == post_letter(post_progress[1:0])) begin
        if (post_progress == 3'd3) begin
          request_seen_next  = 1'b1;
          post_progress_next = 3'd0;
        end else begin
          post_progress_next = post_progress + 3'd1;
        end
      end else begin
        post_progress_next = (data == CHAR_P) ? 3'd1 : 3'd0;
      end
    end
  end

  assign short_f  = byte_count_next < MIN_FRAME_BYTES;
  assign tcp_f    = ~short_f && protocol_code_next == PROTO_TCP;
  assign udp_f    = ~short_f && protocol_code_next == PROTO_UDP;
  assign ports_ok = byte_count_next >= t16 + 16'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      ip_header_words  <= '0;
      protocol_code    <= '0;
      tcp_header_words <= '0;
      source_port      <= '0;
      dest_port        <= '0;
      source_ip        <= '0;
      dest_ip          <= '0;
      get_progress     <= '0;
      post_progress    <= '0;
      request_seen     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (in_accept) begin
        if (last) begin
          // frame done: clear for the next one
          byte_count       <= '0;
          ip_header_words  <= '0;
          protocol_code    <= '0;
          tcp_header_words <= '0;
          source_port      <= '0;
          dest_port        <= '0;
          source_ip        <= '0;
          dest_ip          <= '0;
          get_progress     <= '0;
          post_progress    <= '0;
          request_seen     <= 1'b0;
        end else begin
          byte_count       <= byte_count_next;
          ip_header_words  <= ip_header_words_next;
          protocol_code    <= protocol_code_next;
          tcp_header_words <= tcp_header_words_next;
          source_port      <= source_port_next;
          dest_port        <= dest_port_next;
          source_ip        <= source_ip_next;
          dest_ip          <= dest_ip_next;
          get_progress     <= get_progress_next;
          post_progress    <= post_progress_next;
          request_seen     <= request_seen_next;
        end
      end

      if (in_accept && last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a frame ends
  always_ff @(posedge clk) begin
    if (in_accept && last) begin
      too_short    <= short_f;
      is_tcp       <= tcp_f;
      is_udp       <= udp_f;
      port_hit     <= tcp_f && ports_ok &&
                      (source_port_next == watch_port || dest_port_next == watch_port);
      http_request <= tcp_f && request_seen_next;
      src_addr     <= short_f ? 32'b0 : source_ip_next;
      dst_addr     <= short_f ? 32'b0 : dest_ip_next;
      frame_len    <= byte_count_next;
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> out_valid)
    else $error("frame end did not produce a result");

  a_last_clears_count: assert property (@(posedge clk) disable iff (rst)
    (in_accept && last) |=> (byte_count == 16'd0))
    else $error("byte count not cleared after frame end");

  a_short_flags_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && too_short) |-> (!is_tcp && !is_udp && !port_hit && !http_request &&
                                  src_addr == 32'b0 && dst_addr == 32'b0))
    else $error("short frame reported header flags");

  a_hit_needs_tcp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (port_hit || http_request)) |-> is_tcp)
    else $error("port hit or http flag without tcp");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    byte_count <= MAX_CNT)
    else $error("byte count beyond frame limit");

endmodule

`default_nettype wire
